// ===== rtl/core/gytc_pkg.sv =====
// ----------------------------------------------------------------------------
// gytc_pkg - shared types and constants of the gyro yaw turn controller
// Fixed-point scales, wrap limits, reciprocal constants and code enums.
// ----------------------------------------------------------------------------
`default_nettype none

package gytc_pkg;

    // Calibration samples averaged into the zero-rate offset
    localparam int CALIB_SAMPLES = 200;

    // One degree of yaw in accumulator units: 131 LSB/(deg/s) * 1000 ms * 256
    localparam longint DEG_UNITS = 64'sd33536000;
    localparam longint HALF_TURN = 180 * DEG_UNITS;
    localparam longint FULL_TURN = 360 * DEG_UNITS;

    // Widths
    localparam int GZ_W   = 16;
    localparam int DT_W   = 8;
    localparam int TGT_W  = 10;
    localparam int CENT_W = 16;
    localparam int TMR_W  = 16;
    localparam int TOL_W  = 33;   // 255 degrees in accumulator units
    localparam int ACC_W  = 36;   // yaw before wrap, target in accumulator units
    localparam int ERR_W  = 37;   // target minus yaw before normalization
    localparam int SUM_W  = $clog2(CALIB_SAMPLES * 32768 + 1) + 1;
    localparam int CNT_W  = $clog2(CALIB_SAMPLES + 1);
    localparam int OFS_W  = 25;   // offset with 8 fraction bits

    // Offset = sum * 256 / CALIB_SAMPLES as (|sum| * CAL_MUL) >> CAL_SHIFT
    localparam int     CAL_SHIFT = 31;
    localparam longint CAL_MUL   =
        ((64'sd1 << (CAL_SHIFT + 8)) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
    localparam int     CAL_MUL_W = $clog2(CAL_MUL + 1);

    // Centidegrees = yaw * 100 / DEG_UNITS = ((|yaw| >> 9) / 655)
    localparam int     CENT_PRE   = 9;
    localparam longint CENT_DIV   = DEG_UNITS / (100 * (64'sd1 << CENT_PRE));
    localparam int     CENT_SHIFT = 34;
    localparam longint CENT_MUL   = ((64'sd1 << CENT_SHIFT) + CENT_DIV - 1) / CENT_DIV;
    localparam int     CENT_MUL_W = $clog2(CENT_MUL + 1);

    // Configuration
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 2'd2;

    localparam logic [TOL_W-1:0] TOL_RESET     = TOL_W'(10 * DEG_UNITS);
    localparam logic [TMR_W-1:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [TMR_W-1:0] MIN_GAP_RESET = 16'd200;

    typedef enum logic [1:0] {
        OP_CALIB     = 2'd0,
        OP_TURN      = 2'd1,
        OP_START     = 2'd2,
        OP_RESET_YAW = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_LEFT  = 2'd1,
        CMD_RIGHT = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_IN_TURN  = 3'd1,
        ST_REACHED  = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_NOT_CAL  = 3'd4,
        ST_CAL_DONE = 3'd5
    } status_t;

    // Calibration unit to turn unit
    typedef struct packed {
        logic                    calibrated;  // offset valid before this beat
        logic                    done;        // this beat completes calibration
        logic signed [OFS_W-1:0] offset;
    } calib_info_t;

    // Result of one beat before the centidegree scaling
    typedef struct packed {
        cmd_t                    cmd;
        status_t                 status;
        logic                    calibrated;
        logic signed [ACC_W-1:0] yaw;
    } stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/gytc_calib.sv =====
// ----------------------------------------------------------------------------
// gytc_calib - zero-rate offset calibration
// Sums calibration samples and turns the mean into an offset with 8 fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gytc_calib
    import gytc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cal_fire,
    input  wire logic signed [GZ_W-1:0] gyro_z,
    output calib_info_t                 info
);

    logic signed [SUM_W-1:0]        sum_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic signed [OFS_W-1:0]        offset_reg;
    logic                           cal_reg;

    logic signed [SUM_W-1:0]        sum_next;
    logic signed [SUM_W-1:0]        sum_neg;
    logic [CNT_W-1:0]               cnt_next;
    logic                           done;
    logic [SUM_W-2:0]               mag;
    logic [SUM_W-1+CAL_MUL_W-1:0]   prod;
    logic [OFS_W-2:0]               quot;
    logic signed [OFS_W-1:0]        offset_next;

    assign sum_next = sum_reg + SUM_W'(gyro_z);
    assign sum_neg  = -sum_next;
    assign cnt_next = cnt_reg + 1'b1;
    assign done     = cal_fire && (cnt_next >= CNT_W'(CALIB_SAMPLES));

    // Truncate toward zero: divide the magnitude, then restore the sign
    assign mag  = sum_next[SUM_W-1] ? sum_neg[SUM_W-2:0] : sum_next[SUM_W-2:0];
    assign prod = mag * CAL_MUL_W'(CAL_MUL);
    assign quot = prod[CAL_SHIFT +: OFS_W-1];
    assign offset_next = sum_next[SUM_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            cnt_reg    <= '0;
            offset_reg <= '0;
            cal_reg    <= 1'b0;
        end
        else if (cal_fire)
        begin
            if (done)
            begin
                sum_reg    <= '0;
                cnt_reg    <= '0;
                offset_reg <= offset_next;
                cal_reg    <= 1'b1;
            end
            else
            begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    assign info.calibrated = cal_reg;
    assign info.done       = done;
    assign info.offset     = offset_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gytc_turn.sv =====
// ----------------------------------------------------------------------------
// gytc_turn - yaw integration and bang-bang turn decision
// Integrates the rate, wraps yaw, runs the turn timers and picks the command.
// ----------------------------------------------------------------------------
`default_nettype none

module gytc_turn
    import gytc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_fire,
    input  wire opcode_t                 opcode,
    input  wire logic signed [GZ_W-1:0]  gyro_z,
    input  wire logic [DT_W-1:0]         elapsed_ms,
    input  wire logic signed [TGT_W-1:0] target_deg,
    input  wire calib_info_t             cal,
    input  wire logic [TOL_W-1:0]        tol_units,
    input  wire logic [TMR_W-1:0]        timeout_ms,
    input  wire logic [TMR_W-1:0]        min_turn_gap_ms,
    output stage_t                       res
);

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(HALF_TURN);
    localparam logic signed [ACC_W-1:0] ACC_FULL = ACC_W'(FULL_TURN);
    localparam logic signed [ACC_W-1:0] ACC_DEG  = ACC_W'(DEG_UNITS);
    localparam logic signed [ERR_W-1:0] ERR_HALF = ERR_W'(HALF_TURN);
    localparam logic signed [ERR_W-1:0] ERR_FULL = ERR_W'(FULL_TURN);

    logic signed [ACC_W-1:0] yaw_reg, yaw_next;
    logic                    have_prev_reg, have_prev_next;
    logic                    active_reg, active_next;
    logic signed [ACC_W-1:0] tgt_units_reg, tgt_units_next;
    logic [TMR_W-1:0]        elapsed_reg, elapsed_next;
    logic [TMR_W-1:0]        since_reg, since_next;

    logic signed [25:0]      delta;
    logic signed [DT_W:0]    dt_s;
    logic signed [34:0]      prod;
    logic signed [ACC_W-1:0] yaw_sum;
    logic signed [ACC_W-1:0] yaw_wrap;
    logic signed [ACC_W-1:0] yaw_int;
    logic signed [ACC_W-1:0] tgt_units;
    logic [TMR_W:0]          te_sum, sl_sum;
    logic [TMR_W-1:0]        te, sl;
    logic signed [ERR_W-1:0] err0, err1, err2, err_neg;
    logic [ERR_W-2:0]        aerr, tol_ext;
    cmd_t                    cmd;
    status_t                 status;

    // Integration: yaw -= (gz*256 - offset) * dt, then one wrap step
    assign delta    = {{2{gyro_z[GZ_W-1]}}, gyro_z, 8'b0} - 26'(cal.offset);
    assign dt_s     = $signed({1'b0, elapsed_ms});
    assign prod     = delta * dt_s;
    assign yaw_sum  = yaw_reg - ACC_W'(prod);
    always_comb
    begin
        if (yaw_sum > ACC_HALF)
            yaw_wrap = yaw_sum - ACC_FULL;
        else if (yaw_sum < -ACC_HALF)
            yaw_wrap = yaw_sum + ACC_FULL;
        else
            yaw_wrap = yaw_sum;
    end
    assign yaw_int = have_prev_reg ? yaw_wrap : yaw_reg;

    assign tgt_units = ACC_W'(target_deg) * ACC_DEG;

    // Saturating timers
    assign te_sum = {1'b0, elapsed_reg} + (TMR_W+1)'(elapsed_ms);
    assign sl_sum = {1'b0, since_reg} + (TMR_W+1)'(elapsed_ms);
    assign te     = te_sum[TMR_W] ? '1 : te_sum[TMR_W-1:0];
    assign sl     = sl_sum[TMR_W] ? '1 : sl_sum[TMR_W-1:0];

    // Error normalized into [-180, 180] degrees; two steps cover the range
    assign err0 = ERR_W'(tgt_units_reg) - ERR_W'(yaw_int);
    always_comb
    begin
        if (err0 > ERR_HALF)
            err1 = err0 - ERR_FULL;
        else if (err0 < -ERR_HALF)
            err1 = err0 + ERR_FULL;
        else
            err1 = err0;
        if (err1 > ERR_HALF)
            err2 = err1 - ERR_FULL;
        else if (err1 < -ERR_HALF)
            err2 = err1 + ERR_FULL;
        else
            err2 = err1;
    end
    assign err_neg = -err2;
    assign aerr    = err2[ERR_W-1] ? err_neg[ERR_W-2:0] : err2[ERR_W-2:0];
    assign tol_ext = (ERR_W-1)'(tol_units);

    always_comb
    begin
        yaw_next       = yaw_reg;
        have_prev_next = have_prev_reg;
        active_next    = active_reg;
        tgt_units_next = tgt_units_reg;
        elapsed_next   = elapsed_reg;
        since_next     = since_reg;
        cmd            = CMD_NONE;
        status         = ST_OK;
        case (opcode)
            OP_CALIB:
            begin
                if (cal.done)
                begin
                    yaw_next = '0;
                    status   = ST_CAL_DONE;
                end
            end
            OP_RESET_YAW:
            begin
                yaw_next = '0;
            end
            OP_START:
            begin
                if (!cal.calibrated)
                    status = ST_NOT_CAL;
                else
                begin
                    yaw_next       = '0;
                    active_next    = 1'b1;
                    tgt_units_next = tgt_units;
                    elapsed_next   = '0;
                    since_next     = '1;
                    status         = ST_IN_TURN;
                end
            end
            OP_TURN:
            begin
                if (!cal.calibrated)
                    status = ST_NOT_CAL;
                else
                begin
                    yaw_next       = yaw_int;
                    have_prev_next = 1'b1;
                    if (active_reg)
                    begin
                        elapsed_next = te;
                        since_next   = sl;
                        if (te >= timeout_ms)
                        begin
                            active_next = 1'b0;
                            cmd         = CMD_STOP;
                            status      = ST_TIMEOUT;
                        end
                        else if (aerr < tol_ext)
                        begin
                            active_next = 1'b0;
                            cmd         = CMD_STOP;
                            status      = ST_REACHED;
                        end
                        else
                        begin
                            status = ST_IN_TURN;
                            if (sl > min_turn_gap_ms && aerr > tol_ext)
                            begin
                                cmd        = (err2 > 0) ? CMD_RIGHT : CMD_LEFT;
                                since_next = '0;
                            end
                            else if (aerr == tol_ext)
                                cmd = CMD_STOP;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg       <= '0;
            have_prev_reg <= 1'b0;
            active_reg    <= 1'b0;
            tgt_units_reg <= '0;
            elapsed_reg   <= '0;
            since_reg     <= '1;
        end
        else if (in_fire)
        begin
            yaw_reg       <= yaw_next;
            have_prev_reg <= have_prev_next;
            active_reg    <= active_next;
            tgt_units_reg <= tgt_units_next;
            elapsed_reg   <= elapsed_next;
            since_reg     <= since_next;
        end
    end

    assign res.cmd        = cmd;
    assign res.status     = status;
    assign res.calibrated = cal.calibrated | cal.done;
    assign res.yaw        = yaw_next;

endmodule

`default_nettype wire

// ===== rtl/core/gytc_out.sv =====
// ----------------------------------------------------------------------------
// gytc_out - yaw scaling and output register
// Converts yaw to truncated centidegrees and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module gytc_out
    import gytc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire stage_t      in_data,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata
);

    logic                        valid_reg;
    logic [23:0]                 data_reg;

    logic signed [ACC_W-1:0]     yaw_neg;
    logic [ACC_W-2:0]            mag;
    logic [ACC_W-2-CENT_PRE:0]   coarse;
    logic [ACC_W-1-CENT_PRE+CENT_MUL_W-1:0] prod;
    logic [CENT_W-2:0]           quot;
    logic signed [CENT_W-1:0]    centi;

    assign yaw_neg = -in_data.yaw;
    assign mag     = in_data.yaw[ACC_W-1] ? yaw_neg[ACC_W-2:0] : in_data.yaw[ACC_W-2:0];
    assign coarse  = mag[ACC_W-2:CENT_PRE];
    assign prod    = coarse * CENT_MUL_W'(CENT_MUL);
    assign quot    = prod[CENT_SHIFT +: CENT_W-1];
    assign centi   = in_data.yaw[ACC_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= {2'b00, in_data.calibrated, centi, in_data.status, in_data.cmd};
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gyro_yaw_turn_controller_core.sv =====
// ----------------------------------------------------------------------------
// gyro_yaw_turn_controller_core - gyro yaw integrator with bang-bang turn control
// Calibrates the gyro offset, integrates yaw and issues turn commands per sample.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  -------  ---  -----------------  -------------------------------------------
//  s_*      in   s_tvalid/s_tready  tuser: opcode; tdata: gyro_z, elapsed_ms,
//                                   target_deg
//  m_*      out  m_tvalid/m_tready  tdata: motor_cmd, status, yaw_centideg,
//                                   calibrated
//  cfg_*    in   cfg_valid/cfg_ready index 0 tolerance_deg, 1 timeout_ms,
//                                   2 min_turn_gap_ms
//
//  One beat per cycle in while the middle stage can take it, one result beat out for each:
//  the state update and command decision finish in the accept cycle, the yaw
//  to centidegree multiply runs in the stage after. The integration multiply
//  followed by the yaw wrap and error normalization sets the cycle time.
//  Reset clears all control state except the command gap timer, which starts
//  saturated; registers return to 10 deg, 5000 ms, 200 ms.
//  A stalled output holds its beat; one more beat is taken into the middle stage.
//  Configuration writes are accepted every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_yaw_turn_controller_core
    import gytc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [39:0]           s_tdata,   // [15:0] gyro_z, [23:16] elapsed_ms,
                                                  // [33:24] target_deg, [39:34] zero
    input  wire logic [1:0]            s_tuser,   // [1:0] opcode

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // [1:0] motor_cmd, [4:2] status,
                                                  // [20:5] yaw_centideg,
                                                  // [21] calibrated, [23:22] zero

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration; tolerance is kept pre-scaled to accumulator units
    logic [TOL_W-1:0] tol_units_reg;
    logic [TMR_W-1:0] timeout_reg;
    logic [TMR_W-1:0] min_gap_reg;
    logic [TOL_W-1:0] tol_units_next;

    logic                    s_fire;
    opcode_t                 opcode;
    logic signed [GZ_W-1:0]  gyro_z;
    logic [DT_W-1:0]         elapsed_ms;
    logic signed [TGT_W-1:0] target_deg;

    calib_info_t cal_info;
    stage_t      res;

    logic   p1_valid_reg;
    stage_t p1_data_reg;
    logic   p1_ready;

    assign cfg_ready      = 1'b1;
    assign tol_units_next = TOL_W'(cfg_data[7:0]) * TOL_W'(DEG_UNITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_units_reg <= TOL_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            min_gap_reg   <= MIN_GAP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TOLERANCE: tol_units_reg <= tol_units_next;
                CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                CFG_MIN_GAP:   min_gap_reg   <= cfg_data;
                default:       ;  // drop writes past the register list
            endcase
        end
    end

    // Unpack the input beat
    assign opcode     = opcode_t'(s_tuser);
    assign gyro_z     = $signed(s_tdata[15:0]);
    assign elapsed_ms = s_tdata[23:16];
    assign target_deg = $signed(s_tdata[33:24]);

    // Accept whenever the middle stage is empty or moving on
    assign s_tready = !p1_valid_reg || p1_ready;
    assign s_fire   = s_tvalid && s_tready;

    gytc_calib u_calib (
        .clk      (clk),
        .rst_n    (rst_n),
        .cal_fire (s_fire && (opcode == OP_CALIB)),
        .gyro_z   (gyro_z),
        .info     (cal_info)
    );

    gytc_turn u_turn (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_fire         (s_fire),
        .opcode          (opcode),
        .gyro_z          (gyro_z),
        .elapsed_ms      (elapsed_ms),
        .target_deg      (target_deg),
        .cal             (cal_info),
        .tol_units       (tol_units_reg),
        .timeout_ms      (timeout_reg),
        .min_turn_gap_ms (min_gap_reg),
        .res             (res)
    );

    // Middle stage: hold the decided beat for the scaling stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (s_tready)
            p1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            p1_data_reg <= res;
    end

    gytc_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (p1_valid_reg),
        .in_ready (p1_ready),
        .in_data  (p1_data_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
